FILE: rtl/tkls_pkg.sv
// Package for the top-K selector: widths, defaults and the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

package tkls_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 32;
  localparam int KEEP_W   = 11;

  // Default depth of the cell chain and the reset value of the K register.
  localparam int MAX_K_DEF = 1024;
  localparam logic [KEEP_W-1:0] KEEP_RST = KEEP_W'(1024);

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic en;    // a sample beat is taken this cycle
    logic fill;  // store not yet full: insert, otherwise replace the minimum
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/tkls_cell.sv
// One cell of the sorted chain: holds a single kept value, ascending from cell 0.
`timescale 1ns / 1ps
`default_nettype none

module tkls_cell #(
  parameter int CNT_W = 11,
  parameter int IDX   = 0
) (
  input  wire                               clk,
  input  wire tkls_pkg::cell_ctrl_t         ctrl,
  input  wire signed [tkls_pkg::SAMPLE_W-1:0] sample,
  input  wire        [CNT_W-1:0]            fill_count,
  input  wire signed [tkls_pkg::SAMPLE_W-1:0] prev_val,
  input  wire                               prev_le,
  input  wire signed [tkls_pkg::SAMPLE_W-1:0] next_val,
  input  wire                               next_lt,
  output logic signed [tkls_pkg::SAMPLE_W-1:0] val,
  output logic                              le,
  output logic                              lt
);
  import tkls_pkg::*;

  logic                       occupied;
  logic signed [SAMPLE_W-1:0] val_next;

  // The cell holds a kept value when its place lies below the fill count.
  assign occupied = (CNT_W'(IDX) < fill_count);
  assign le       = occupied && (val <= sample);
  assign lt       = occupied && (val < sample);

  // Insertion shifts larger values up by one place; replacement shifts
  // smaller values down by one place, dropping the minimum from cell 0.
  always_comb begin
    if (ctrl.fill) begin
      if (le) begin
        val_next = val;
      end else if (!prev_le) begin
        val_next = prev_val;
      end else begin
        val_next = sample;
      end
    end else begin
      if (next_lt) begin
        val_next = next_val;
      end else if (lt) begin
        val_next = sample;
      end else begin
        val_next = val;
      end
    end
  end

  // Stored value; payload only, so no reset.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      val <= val_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/top_k_largest_selector.sv
// Output: the result of each sample beat is registered into the output register.
// Throughput: one sample per cycle while the result channel does not stall; every
// cell compares the sample in parallel, and insertion or replacement is combinational.
// Reset: the store is empty, the K register returns to 1024 and the output is empty.
// The cell values themselves are not reset; only places below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none

module top_k_largest_selector #(
  parameter int MAX_K = tkls_pkg::MAX_K_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // Configuration write channel.
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire        [tkls_pkg::KEEP_W-1:0]   keep_count,
  // Sample channel.
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire signed [tkls_pkg::SAMPLE_W-1:0] sample,
  input  wire                                 last_sample,
  // Result channel.
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic signed [tkls_pkg::SAMPLE_W-1:0] kth_largest,
  output logic                                full_res
);
  import tkls_pkg::*;

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int EXT_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  logic [KEEP_W-1:0]          keep_reg;
  logic [CNT_W-1:0]           fill_count;
  logic [CNT_W-1:0]           fill_count_next;
  logic [CNT_W-1:0]           active_k;
  logic [CNT_W-1:0]           eff_k;
  logic [CNT_W-1:0]           cur_k;
  logic [EXT_W-1:0]           keep_ext;
  logic [CNT_W:0]             fill_inc;
  logic                       accept;
  logic                       fill_mode;
  cell_ctrl_t                 ctrl;
  logic signed [SAMPLE_W-1:0] kth_next;
  logic                       full_next;

  // Chain links, with one spare place at index MAX_K for the boundary values.
  logic signed [SAMPLE_W-1:0] val_chain [0:MAX_K];
  logic                       le_chain  [0:MAX_K];
  logic                       lt_chain  [0:MAX_K];

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_reg <= KEEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      keep_reg <= keep_count;
    end
  end

  // K in force: zero counts as one, values above the chain depth saturate.
  assign keep_ext = EXT_W'(keep_reg);
  always_comb begin
    if (keep_ext == '0) begin
      eff_k = CNT_W'(1);
    end else if (keep_ext > EXT_W'(MAX_K)) begin
      eff_k = CNT_W'(MAX_K);
    end else begin
      eff_k = keep_ext[CNT_W-1:0];
    end
  end

  // The K of a set is taken with its first sample.
  assign cur_k     = (fill_count == '0) ? eff_k : active_k;
  assign fill_mode = (fill_count < cur_k);
  assign fill_inc  = {1'b0, fill_count} + (CNT_W + 1)'(1);

  assign ctrl.en   = accept;
  assign ctrl.fill = fill_mode;

  // Boundary links: cell 0 always takes the sample when it is the insert point,
  // and the top cell never pulls from above.
  assign le_chain[MAX_K]  = 1'b1;
  assign lt_chain[MAX_K]  = 1'b0;
  assign val_chain[MAX_K] = sample;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_K; gi++) begin : g_cell
      logic signed [SAMPLE_W-1:0] prev_v;
      logic                       prev_l;

      if (gi == 0) begin : g_first
        assign prev_v = sample;
        assign prev_l = le_chain[MAX_K];
      end else begin : g_rest
        assign prev_v = val_chain[gi-1];
        assign prev_l = le_chain[gi-1];
      end

      tkls_cell #(
        .CNT_W (CNT_W),
        .IDX   (gi)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .sample     (sample),
        .fill_count (fill_count),
        .prev_val   (prev_v),
        .prev_le    (prev_l),
        .next_val   (val_chain[gi+1]),
        .next_lt    (lt_chain[gi+1]),
        .val        (val_chain[gi]),
        .le         (le_chain[gi]),
        .lt         (lt_chain[gi])
      );
    end
  endgenerate

  // New minimum, which is what cell 0 will hold after this beat, and the full flag.
  always_comb begin
    if (fill_mode) begin
      kth_next  = le_chain[0] ? val_chain[0] : sample;
      full_next = (fill_inc >= {1'b0, cur_k});
    end else begin
      if (lt_chain[1]) begin
        kth_next = val_chain[1];
      end else if (lt_chain[0]) begin
        kth_next = sample;
      end else begin
        kth_next = val_chain[0];
      end
      full_next = 1'b1;
    end
  end

  // Fill count: grows while filling, clears after the last sample of a set.
  always_comb begin
    if (last_sample) begin
      fill_count_next = '0;
    end else if (fill_mode) begin
      fill_count_next = fill_inc[CNT_W-1:0];
    end else begin
      fill_count_next = fill_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      active_k   <= CNT_W'(1);
    end else if (accept) begin
      fill_count <= fill_count_next;
      active_k   <= cur_k;
    end
  end

  // Output register: holds the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kth_largest <= kth_next;
      full_res    <= full_next;
    end
  end

endmodule

`default_nettype wire
